FILE: hdl/uls_pkg.sv
// Package: sizes, operation codes, word types and helpers for the list store.
`timescale 1ns / 1ps
package uls_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_SEARCH = 3'd1,
        OP_DELETE = 3'd2,
        OP_NEXT   = 3'd3,
        OP_RESET  = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_MRD,
        S_MWR,
        S_DEL_END,
        S_NRD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] key_value;
    } t_in_word;

    typedef struct packed {
        logic        success;
        logic [31:0] result_value;
        logic [4:0]  entry_count;
        logic        list_full;
    } t_out_word;

    // Status from the controller to the top level.
    typedef struct packed {
        logic             idle;
        logic             res_valid;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] cursor;
    } t_ctrl_stat;

    // Logical position k (0 = front) to physical RAM address.
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] k);
        logic [IDX_W:0] s;
        s = {1'b0, head} + {1'b0, k};
        if (s >= (IDX_W+1)'(CAPACITY))
            s = s - (IDX_W+1)'(CAPACITY);
        return s[IDX_W-1:0];
    endfunction

endpackage

FILE: hdl/uls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module uls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en)
            r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hdl/uls_ctrl.sv
// Sequencer: decodes operations and reads, modifies and writes the entry RAM.
`timescale 1ns / 1ps
module uls_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  uls_pkg::t_in_word                i_word,
    input  logic                             i_res_take,
    output uls_pkg::t_out_word               o_res,
    output uls_pkg::t_ctrl_stat              o_stat,
    output logic                             o_wr_en,
    output logic [uls_pkg::IDX_W-1:0]        o_wr_addr,
    output logic [uls_pkg::VALUE_BITS-1:0]   o_wr_data,
    output logic                             o_rd_en,
    output logic [uls_pkg::IDX_W-1:0]        o_rd_addr,
    input  logic [uls_pkg::VALUE_BITS-1:0]   i_rd_data
);
    import uls_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(CAPACITY - 1);

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_cursor, n_cursor;
    logic [CNT_W-1:0]      r_k, n_k;
    logic [CNT_W-1:0]      r_p, n_p;
    logic [2:0]            r_op, n_op;
    logic [VALUE_BITS-1:0] r_key, n_key;
    logic                  r_ok, n_ok;
    logic [31:0]           r_val, n_val;
    logic [CNT_W-1:0]      k1, k2, new_cnt, p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_p   <= n_p;
        r_op  <= n_op;
        r_key <= n_key;
        r_ok  <= n_ok;
        r_val <= n_val;
    end

    always_comb begin
        k1      = r_k + CNT_W'(1);
        k2      = r_k + CNT_W'(2);
        p1      = r_p + CNT_W'(1);
        new_cnt = r_count - CNT_W'(1);

        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_k      = r_k;
        n_p      = r_p;
        n_op     = r_op;
        n_key    = r_key;
        n_ok     = r_ok;
        n_val    = r_val;

        o_wr_en   = 1'b0;
        o_wr_addr = phys_addr(r_head, r_k[IDX_W-1:0]);
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = phys_addr(r_head, r_k[IDX_W-1:0]);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_word.operation;
                    n_key   = i_word.key_value[VALUE_BITS-1:0];
                    n_ok    = 1'b0;
                    n_val   = '0;
                    n_k     = '0;
                    n_state = S_DONE;
                    unique case (i_word.operation)
                        OP_INSERT: begin
                            if (r_count < CAP_C) begin
                                n_head    = (r_head == '0) ? LAST : r_head - IDX_W'(1);
                                o_wr_en   = 1'b1;
                                o_wr_addr = n_head;
                                o_wr_data = i_word.key_value[VALUE_BITS-1:0];
                                n_count   = r_count + CNT_W'(1);
                                n_cursor  = CNT_W'(1);
                                n_ok      = 1'b1;
                            end
                        end
                        OP_SEARCH, OP_DELETE: begin
                            if (r_count != '0)
                                n_state = S_SRD;
                        end
                        OP_NEXT: begin
                            if (r_cursor != '0 && r_cursor <= r_count) begin
                                n_k     = r_cursor - CNT_W'(1);
                                n_state = S_NRD;
                            end
                        end
                        OP_RESET: n_cursor = (r_count != '0) ? CNT_W'(1) : '0;
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SRD: begin
                o_rd_en = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_rd_data == r_key) begin
                    if (r_op == OP_SEARCH) begin
                        n_ok    = 1'b1;
                        n_val   = 32'(r_key);
                        n_state = S_DONE;
                    end else begin
                        n_p     = r_k;
                        n_state = (k1 < r_count) ? S_MRD : S_DEL_END;
                    end
                end else if (k1 < r_count) begin
                    n_k     = k1;
                    n_state = S_SRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = phys_addr(r_head, k1[IDX_W-1:0]);
                n_state   = S_MWR;
            end
            S_MWR: begin
                o_wr_en = 1'b1;
                n_k     = k1;
                n_state = (k2 < r_count) ? S_MRD : S_DEL_END;
            end
            S_DEL_END: begin
                n_count = new_cnt;
                if (r_cursor > p1)
                    n_cursor = r_cursor - CNT_W'(1);
                else if (r_cursor == p1 && r_cursor > new_cnt)
                    n_cursor = '0;
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_NRD: begin
                o_rd_en  = 1'b1;
                n_state  = S_DONE;
                n_ok     = 1'b1;
                n_cursor = (r_cursor < r_count) ? r_cursor + CNT_W'(1) : '0;
            end
            S_DONE: begin
                if (i_res_take)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A successful next takes its value straight from the registered read data.
    always_comb begin
        o_res.success      = r_ok;
        o_res.result_value = (r_op == OP_NEXT && r_ok) ? 32'(i_rd_data) : r_val;
        o_res.entry_count  = 5'(r_count);
        o_res.list_full    = (r_count == CAP_C);
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_stat.count     = r_count;
    assign o_stat.cursor    = r_cursor;
endmodule

FILE: hdl/unordered_list_store_top.sv
// Top level: bounded newest-first list store with output register.
//
//  channel | valid      | ready       | word
//  --------+------------+-------------+---------------------------
//  in      | i_in_valid | o_in_ready  | i_in  (operation, key)
//  out     | o_out_valid| i_out_ready | o_out (success, value, count, full)
//
// Sequence: insert, reset, clear and unused codes go from idle straight to
// the result register; next first reads the entry at the cursor; search
// and delete read and compare each entry in turn on a non-empty list; a
// delete that hits then closes up each entry behind the match, one read
// and one write per entry, on the entry RAM's single read port.
// Reset: synchronous, active low; empties the list and parks the cursor
// at the end. RAM contents are not cleared.
// Stalls: a finished word waits in the output register; the next word is
// accepted while it waits.
`timescale 1ns / 1ps
module unordered_list_store_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uls_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output uls_pkg::t_out_word o_out
);
    import uls_pkg::*;

    t_ctrl_stat            stat;
    t_out_word             res;
    t_out_word             r_out;
    logic                  r_out_valid;
    logic                  take;
    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_data, rd_data;

    // Result moves to the output register once the register is free.
    assign take       = stat.res_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = stat.idle;

    uls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && o_in_ready),
        .i_word     (i_in),
        .i_res_take (take),
        .o_res      (res),
        .o_stat     (stat),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    uls_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take)
            r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Count never exceeds the store size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Cursor always points inside the list or at the end.
    a_cursor_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.cursor <= stat.count)
        else $error("cursor beyond last entry");

    // Full flag agrees with the reported count.
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.list_full == (o_out.entry_count == 5'(CAPACITY))))
        else $error("full flag disagrees with count");

    // No new word is taken while a result is still inside the controller.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_valid |-> !o_in_ready)
        else $error("input ready while result pending");
endmodule

FILE: sim/unordered_list_store_checker.sv
// Checker: watches both channels of the list store, predicts each output word and compares.
`timescale 1ns / 1ps
module unordered_list_store_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  uls_pkg::t_in_word  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  uls_pkg::t_out_word i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    import uls_pkg::*;

    logic [31:0]      list_vals [CAPACITY];
    int               list_len;
    int               cur_pos;
    t_out_word        pending_words [$];

    // Model one operation on the shadow list; returns the word it should produce.
    function automatic t_out_word apply_op(t_in_word w);
        t_out_word r;
        int        hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_vals[i] == w.key_value) hit = i;
        case (w.operation)
            OP_INSERT: if (list_len < CAPACITY) begin
                for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
                list_vals[0] = w.key_value;
                list_len++;
                cur_pos   = 1;
                r.success = 1'b1;
            end
            OP_SEARCH: if (hit >= 0) begin
                r.success      = 1'b1;
                r.result_value = w.key_value;
            end
            OP_DELETE: if (hit >= 0) begin
                for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                list_len--;
                if (cur_pos > hit + 1) cur_pos--;
                else if (cur_pos == hit + 1 && cur_pos > list_len) cur_pos = 0;
                r.success = 1'b1;
            end
            OP_NEXT: if (cur_pos != 0 && cur_pos <= list_len) begin
                r.result_value = list_vals[cur_pos-1];
                r.success      = 1'b1;
                cur_pos        = (cur_pos < list_len) ? cur_pos + 1 : 0;
            end
            OP_RESET: cur_pos = (list_len > 0) ? 1 : 0;
            OP_CLEAR: begin
                list_len = 0;
                cur_pos  = 0;
            end
            default: ;
        endcase
        r.entry_count = 5'(list_len);
        r.list_full   = (list_len >= CAPACITY);
        return r;
    endfunction

    assign o_pending = pending_words.size();

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            list_len     = 0;
            cur_pos      = 0;
            o_fail_count <= 0;
            pending_words.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                pending_words.push_back(apply_op(i_in));
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, i_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_words.pop_front();
                    if (want !== i_out) begin
                        $display("%0t: mismatch expected %b/%h/%0d/%b actual %b/%h/%0d/%b",
                                 $time, want.success, want.result_value, want.entry_count,
                                 want.list_full, i_out.success, i_out.result_value,
                                 i_out.entry_count, i_out.list_full);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/unordered_list_store_top_test.sv
// Testbench top: drives operation words into the list store and reports the verdict.
`timescale 1ns / 1ps
module unordered_list_store_top_test;
    import uls_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    logic [31:0] recent_keys [8];

    localparam int         STALL_LIMIT = 2000;
    // Operation codes with no function: the block ignores them.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    unordered_list_store_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_word)
    );

    unordered_list_store_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: any cycle without a handshake on either channel counts.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** unordered_list_store_top: FAILED **");
            $finish;
        end
    end

    // Receiver: for each word, hold ready low for a random gap or none, then wait for it.
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
        end
    end

    // Send one word after a random gap, or at once with no_gap; valid is held until accepted.
    task automatic send_word(input logic [2:0] op, input logic [31:0] key, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_word.operation <= op;
        in_word.key_value <= key;
        @(posedge clk iff in_ready);
    endtask

    // Keys drawn mostly from a small pool of recent inserts so searches and deletes hit.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return 32'($urandom_range(0, 7));
            default: return recent_keys[$urandom_range(0, 7)];
        endcase
    endfunction

    initial begin
        logic [31:0] k;
        int          sel;
        bit          burst;
        in_valid    = 1'b0;
        in_word     = '0;
        rst_n       = 1'b0;
        idle_cycles = 0;
        for (int i = 0; i < 8; i++) recent_keys[i] = 32'(i);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list cases, field extremes, fill past capacity.
        send_word(OP_NEXT, 32'h0, 0);
        send_word(OP_RESET, 32'h0, 0);
        send_word(OP_SEARCH, 32'hFFFF_FFFF, 0);
        send_word(OP_DELETE, 32'h0, 0);
        send_word(OP_INSERT, 32'h0, 0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 0);
        send_word(OP_SEARCH, 32'h0, 0);
        send_word(OP_NEXT, 32'h0, 0);
        send_word(OP_NEXT, 32'h0, 0);
        send_word(OP_NEXT, 32'h0, 0);
        for (int i = 0; i < 15; i++) send_word(OP_INSERT, 32'h100 + i, 1);
        send_word(OP_DELETE, 32'h0, 0);      // back entry with cursor at the front
        send_word(OP_SPARE_LO, 32'h5, 0);
        send_word(OP_SPARE_HI, 32'h5, 0);
        send_word(OP_CLEAR, 32'h0, 0);

        // Random: mostly insert/search/delete/next on a pool of keys.
        for (int n = 0; n < 900; n++) begin
            burst = ($urandom_range(0, 9) < 2);
            sel   = $urandom_range(0, 99);
            k     = pick_key();
            if (sel < 30) begin
                recent_keys[$urandom_range(0, 7)] = k;
                send_word(OP_INSERT, k, burst);
            end else if (sel < 48) send_word(OP_SEARCH, k, burst);
            else if (sel < 68)     send_word(OP_DELETE, k, burst);
            else if (sel < 88)     send_word(OP_NEXT, k, burst);
            else if (sel < 94)     send_word(OP_RESET, k, burst);
            else if (sel < 97)     send_word(OP_CLEAR, k, burst);
            else send_word(($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO, k, burst);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("** unordered_list_store_top: PASSED **");
        else
            $display("** unordered_list_store_top: FAILED **");
        $finish;
    end

endmodule
